[rtl/rts_pkg.sv]
// Package for the rectangle transform stack.
// Holds command and status codes, the saved-state record and the saturation helpers.
// No dependencies.
package rts_pkg;

  localparam int unsigned StackDepthDefault = 16;
  localparam logic [23:0] FactorOne = 24'h01_0000;
  localparam logic [23:0] FactorMax = 24'hFF_FFFF;
  localparam logic signed [31:0] SatMax = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SatMin = -32'sh7FFF_FFFF - 32'sh1;

  typedef enum logic [2:0] {
    REQ_TRANSLATE = 3'd0,
    REQ_SCALE     = 3'd1,
    REQ_PUSH      = 3'd2,
    REQ_POP       = 3'd3,
    REQ_RESTORE   = 3'd4,
    REQ_RECT      = 3'd5
  } req_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DONE
  } fsm_e;

  typedef struct packed {
    logic signed [31:0] off_x;
    logic signed [31:0] off_y;
    logic [23:0]        fac_x;
    logic [23:0]        fac_y;
  } state_t;

  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctl_t;

  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    logic signed [31:0] r;
    if (v > 48'(SatMax)) begin
      r = SatMax;
    end else if (v < 48'(SatMin)) begin
      r = SatMin;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic [23:0] sat_factor(input logic [31:0] v);
    logic [23:0] r;
    if (|v[31:24]) begin
      r = FactorMax;
    end else begin
      r = v[23:0];
    end
    return r;
  endfunction

endpackage

[rtl/rts_req_if.sv]
// Command channel of the rectangle transform stack.
// Carries one command word with valid/ready; no dependencies.
interface rts_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         req_type;
  logic signed [15:0] arg_x;
  logic signed [15:0] arg_y;
  logic [15:0]        arg_w;
  logic [15:0]        arg_h;
  logic [23:0]        scale_x;
  logic [23:0]        scale_y;

  modport source (
    output valid, req_type, arg_x, arg_y, arg_w, arg_h, scale_x, scale_y,
    input  ready
  );
  modport sink (
    input  valid, req_type, arg_x, arg_y, arg_w, arg_h, scale_x, scale_y,
    output ready
  );
endinterface

[rtl/rts_rsp_if.sv]
// Result channel of the rectangle transform stack.
// Carries one result word with valid/ready; no dependencies.
interface rts_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] rect_x;
  logic signed [31:0] rect_y;
  logic signed [31:0] rect_w;
  logic signed [31:0] rect_h;
  logic [1:0]         status;

  modport source (
    output valid, rect_x, rect_y, rect_w, rect_h, status,
    input  ready
  );
  modport sink (
    input  valid, rect_x, rect_y, rect_w, rect_h, status,
    output ready
  );
endinterface

[rtl/rts_cell.sv]
// One entry of the shifting save stack.
// Takes its neighbour's entry on push or pop; depends on rts_pkg.
module rts_cell (
  input  logic               clk_i,
  input  rts_pkg::cell_ctl_t ctl_i,
  input  rts_pkg::state_t    from_prev_i,
  input  rts_pkg::state_t    from_next_i,
  output rts_pkg::state_t    entry_o
);

  rts_pkg::state_t entry_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.push) begin
      entry_q <= from_prev_i;
    end else if (ctl_i.pop) begin
      entry_q <= from_next_i;
    end
  end

  assign entry_o = entry_q;

endmodule

[rtl/rect_transform_stack.sv]
// Rectangle transform stack: scale-and-translate state with a shifting save stack.
// A command word is registered, multiplied, then added and saturated into the output register;
// the next command is taken only once that result has been written there.
// A new command is taken while the previous result still waits in the output register.
// Reset sets translation to zero, scale to 1.0 and empties the stack; the stack
// cells themselves are not cleared. Depends on rts_pkg, rts_req_if, rts_rsp_if, rts_cell.
module rect_transform_stack #(
  parameter int unsigned STACK_DEPTH = rts_pkg::StackDepthDefault
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  rts_req_if.sink  req_i,
  rts_rsp_if.source rsp_o
);

  localparam int unsigned CntW = $clog2(STACK_DEPTH + 1);

  rts_pkg::fsm_e   fsm_q, fsm_d;
  rts_pkg::state_t cur_q, cur_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  logic [2:0]         cmd_q;
  logic signed [15:0] ax_q, ay_q;
  logic [15:0]        aw_q, ah_q;
  logic [23:0]        sx_q, sy_q;

  logic signed [49:0] prod_ax_q, prod_ay_q;
  logic signed [42:0] prod_ex_q, prod_ey_q;

  logic               out_valid_q;
  logic signed [31:0] out_x_q, out_y_q, out_w_q, out_h_q;
  logic [1:0]         out_st_q;

  logic               accept, mul_en, done_fire;
  logic               full, empty;
  logic signed [31:0] res_x, res_y, res_w, res_h;
  rts_pkg::status_e   res_st;
  rts_pkg::cell_ctl_t cell_ctl;
  rts_pkg::state_t    chain [STACK_DEPTH];

  logic signed [24:0] opa_x, opa_y, fac_xs, fac_ys;
  logic signed [17:0] end_x, end_y;
  logic signed [33:0] sa_x, sa_y;
  logic signed [26:0] se_x, se_y;

  assign full  = (cnt_q == CntW'(STACK_DEPTH));
  assign empty = (cnt_q == '0);

  // Control sequence.
  always_comb begin
    fsm_d     = fsm_q;
    req_i.ready = 1'b0;
    mul_en    = 1'b0;
    done_fire = 1'b0;
    unique case (fsm_q)
      rts_pkg::ST_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          fsm_d = rts_pkg::ST_MUL;
        end
      end
      rts_pkg::ST_MUL: begin
        mul_en = 1'b1;
        fsm_d  = rts_pkg::ST_DONE;
      end
      rts_pkg::ST_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          done_fire = 1'b1;
          fsm_d     = rts_pkg::ST_IDLE;
        end
      end
      default: fsm_d = rts_pkg::ST_IDLE;
    endcase
  end

  assign accept = req_i.valid && req_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q <= rts_pkg::ST_IDLE;
    end else begin
      fsm_q <= fsm_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= req_i.req_type;
      ax_q  <= req_i.arg_x;
      ay_q  <= req_i.arg_y;
      aw_q  <= req_i.arg_w;
      ah_q  <= req_i.arg_h;
      sx_q  <= req_i.scale_x;
      sy_q  <= req_i.scale_y;
    end
  end

  // Multiply stage: one product per axis against the scale or the start
  // coordinate, and one against the rectangle's far edge.
  assign fac_xs = $signed({1'b0, cur_q.fac_x});
  assign fac_ys = $signed({1'b0, cur_q.fac_y});
  assign opa_x  = (cmd_q == rts_pkg::REQ_SCALE) ? $signed({1'b0, sx_q}) : 25'(ax_q);
  assign opa_y  = (cmd_q == rts_pkg::REQ_SCALE) ? $signed({1'b0, sy_q}) : 25'(ay_q);
  assign end_x  = 18'(ax_q) + $signed({2'b00, aw_q});
  assign end_y  = 18'(ay_q) + $signed({2'b00, ah_q});

  always_ff @(posedge clk_i) begin
    if (mul_en) begin
      prod_ax_q <= opa_x * fac_xs;
      prod_ay_q <= opa_y * fac_ys;
      prod_ex_q <= 43'(end_x) * 43'(fac_xs);
      prod_ey_q <= 43'(end_y) * 43'(fac_ys);
    end
  end

  // The arithmetic shift of a signed product gives the floor directly.
  assign sa_x = $signed(prod_ax_q[49:16]);
  assign sa_y = $signed(prod_ay_q[49:16]);
  assign se_x = $signed(prod_ex_q[42:16]);
  assign se_y = $signed(prod_ey_q[42:16]);

  always_comb begin
    cur_d  = cur_q;
    cnt_d  = cnt_q;
    res_x  = '0;
    res_y  = '0;
    res_w  = '0;
    res_h  = '0;
    res_st = rts_pkg::STATUS_OK;
    cell_ctl = '0;
    unique case (cmd_q)
      rts_pkg::REQ_TRANSLATE: begin
        cur_d.off_x = rts_pkg::sat32(48'(cur_q.off_x) + 48'(sa_x));
        cur_d.off_y = rts_pkg::sat32(48'(cur_q.off_y) + 48'(sa_y));
      end
      rts_pkg::REQ_SCALE: begin
        cur_d.fac_x = rts_pkg::sat_factor(prod_ax_q[47:16]);
        cur_d.fac_y = rts_pkg::sat_factor(prod_ay_q[47:16]);
      end
      rts_pkg::REQ_PUSH: begin
        if (full) begin
          res_st = rts_pkg::STATUS_FULL;
        end else begin
          cell_ctl.push = 1'b1;
          cnt_d = cnt_q + CntW'(1);
        end
      end
      rts_pkg::REQ_POP: begin
        if (empty) begin
          res_st = rts_pkg::STATUS_EMPTY;
        end else begin
          cell_ctl.pop = 1'b1;
          cur_d = chain[0];
          cnt_d = cnt_q - CntW'(1);
        end
      end
      rts_pkg::REQ_RESTORE: begin
        if (empty) begin
          res_st = rts_pkg::STATUS_EMPTY;
        end else begin
          cur_d = chain[0];
        end
      end
      rts_pkg::REQ_RECT: begin
        res_x = rts_pkg::sat32(48'(cur_q.off_x) + 48'(sa_x));
        res_y = rts_pkg::sat32(48'(cur_q.off_y) + 48'(sa_y));
        res_w = rts_pkg::sat32(48'(se_x) - 48'(sa_x));
        res_h = rts_pkg::sat32(48'(se_y) - 48'(sa_y));
      end
      default: begin
      end
    endcase
    if (!done_fire) begin
      cell_ctl = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q.off_x <= '0;
      cur_q.off_y <= '0;
      cur_q.fac_x <= rts_pkg::FactorOne;
      cur_q.fac_y <= rts_pkg::FactorOne;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (done_fire) begin
        cur_q       <= cur_d;
        cnt_q       <= cnt_d;
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (done_fire) begin
      out_x_q  <= res_x;
      out_y_q  <= res_y;
      out_w_q  <= res_w;
      out_h_q  <= res_h;
      out_st_q <= res_st;
    end
  end

  assign rsp_o.valid  = out_valid_q;
  assign rsp_o.rect_x = out_x_q;
  assign rsp_o.rect_y = out_y_q;
  assign rsp_o.rect_w = out_w_q;
  assign rsp_o.rect_h = out_h_q;
  assign rsp_o.status = out_st_q;

  // Save stack: the top entry sits in the first cell.
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    rts_pkg::state_t prev_s, next_s;
    if (i == 0) begin : g_first
      assign prev_s = cur_q;
    end else begin : g_mid
      assign prev_s = chain[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_last
      assign next_s = '0;
    end else begin : g_inner
      assign next_s = chain[i+1];
    end
    rts_cell u_cell (
      .clk_i       (clk_i),
      .ctl_i       (cell_ctl),
      .from_prev_i (prev_s),
      .from_next_i (next_s),
      .entry_o     (chain[i])
    );
  end

endmodule
